>>> design/assert_macros.svh
// Assertion macros shared by the frame RMS meter RTL.
// Every assertion samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that must hold at every clock edge.
`define FRM_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define FRM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FRM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/frm_pkg.sv
// Package for the frame RMS meter: widths, limits and the result type
// of the shared compare-subtract unit. No dependencies.
package frm_pkg;

  // Input sample and its square
  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 2 * SAMPLE_W - 1;

  // Frame length limit and sample counter
  localparam int MAX_FRAME = 4096;
  localparam int CNT_W     = $clog2(MAX_FRAME + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME);

  // Running sum of squares, saturating at all ones
  localparam int SUM_W = 43;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Output fixed point: 8 fractional bits, so the mean square is scaled by 2^16
  localparam int FRAC_BITS = 8;
  localparam int DIVD_W    = SUM_W + 2 * FRAC_BITS;

  // Root: the mean square never exceeds 2^30, so the scaled quotient fits 48 bits
  localparam int LEVEL_W    = 24;
  localparam int ROOT_W     = LEVEL_W;
  localparam int QS_W       = 2 * ROOT_W;
  localparam int SQRT_STEPS = ROOT_W;

  // Shared trial-subtract width: covers the root's shifted partial remainder
  localparam int UNIT_W = ROOT_W + 3;

  // Step counter covers the longer of the two iterations
  localparam int STEP_W = $clog2(DIVD_W);

  typedef struct packed {
    logic              ge;
    logic [UNIT_W-1:0] diff;
  } unit_res_t;

endpackage

>>> design/frm_trial_sub.sv
// Shared compare-subtract unit of the frame RMS meter.
// Used one step per cycle by both the divider and the square root. Uses frm_pkg.
module frm_trial_sub import frm_pkg::*; (
  input  logic [UNIT_W-1:0] a,
  input  logic [UNIT_W-1:0] b,
  output unit_res_t         res
);

  logic [UNIT_W:0] d;

  // One wide subtract; no borrow means a >= b
  assign d        = {1'b0, a} - {1'b0, b};
  assign res.ge   = ~d[UNIT_W];
  assign res.diff = d[UNIT_W-1:0];

endmodule

>>> design/frame_rms_meter.sv
// Top level of the frame RMS meter: sequencer, accumulator, divider and
// square-root registers around the shared unit. Uses frm_pkg, frm_trial_sub
// and assert_macros.svh.
//
// Usage: present sample and frame_end with start high; the item is taken at
// a rising edge where start is high and busy is low. Each item's square is
// added to a running sum in the cycle after it is taken, so a sample that
// does not end a frame holds busy high only while its square is added, so
// no new item is taken until it is in the sum. An item with frame_end high
// then runs a restoring divide of the sum (scaled by 2^16) by the sample
// count and a bit-pair square root, both one step a cycle through the one
// compare-subtract unit. done pulses for one cycle with rms_level and
// overlong once the last root step is registered, while busy is low.
// Frames longer than MAX_FRAME samples keep the first MAX_FRAME samples and
// report overlong. The receiver cannot stall: the result is valid for the
// done cycle only. Synchronous reset clears the sum, count and sequencer.
`include "assert_macros.svh"

module frame_rms_meter import frm_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       frame_end,
  output logic                       done,
  output logic [LEVEL_W-1:0]         rms_level,
  output logic                       overlong
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ACC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_SQRT = 2'd3;

  logic [1:0]                  state;
  logic                        accept;
  logic signed [2*SAMPLE_W-1:0] square_full;
  logic [SQ_W-1:0]             sq;
  logic                        last;
  logic [SUM_W-1:0]            square_sum;
  logic [SUM_W-1:0]            sum_next;
  logic [SUM_W:0]              sum_add;
  logic [CNT_W-1:0]            sample_count;
  logic [CNT_W-1:0]            count_next;
  logic                        overflow_seen;
  logic                        ovf_next;
  logic [DIVD_W-1:0]           num;
  logic [UNIT_W-1:0]           rem;
  logic [ROOT_W-1:0]           root;
  logic [ROOT_W-1:0]           root_next;
  logic [STEP_W-1:0]           step;
  logic [UNIT_W-1:0]           unit_a;
  logic [UNIT_W-1:0]           unit_b;
  unit_res_t                   unit_res;

  assign busy        = (state != S_IDLE);
  assign accept      = start && !busy;
  assign square_full = sample * sample;

  // Accumulate with the frame-length limit and sum saturation
  always_comb begin
    sum_add    = {1'b0, square_sum} + (SUM_W+1)'(sq);
    sum_next   = square_sum;
    count_next = sample_count;
    ovf_next   = overflow_seen;
    if (sample_count >= MAX_CNT) begin
      ovf_next = 1'b1;
    end else begin
      sum_next   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
      count_next = sample_count + 1'b1;
    end
  end

  // Operand select for the shared unit: divide step or root step
  always_comb begin
    if (state == S_DIV) begin
      unit_a = UNIT_W'({rem[CNT_W-1:0], num[DIVD_W-1]});
      unit_b = UNIT_W'(sample_count);
    end else begin
      unit_a = {rem[UNIT_W-3:0], num[QS_W-1 -: 2]};
      unit_b = UNIT_W'({root, 2'b01});
    end
  end

  assign root_next = {root[ROOT_W-2:0], unit_res.ge};

  frm_trial_sub u_sub (
    .a   (unit_a),
    .b   (unit_b),
    .res (unit_res)
  );

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      square_sum    <= '0;
      sample_count  <= '0;
      overflow_seen <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sq    <= square_full[SQ_W-1:0];
            last  <= frame_end;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          square_sum    <= sum_next;
          sample_count  <= count_next;
          overflow_seen <= ovf_next;
          if (!last) begin
            state <= S_IDLE;
          end else if (count_next == '0) begin
            // empty frame guard: level reads zero
            rms_level     <= '0;
            overlong      <= ovf_next;
            done          <= 1'b1;
            square_sum    <= '0;
            sample_count  <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end else begin
            num   <= {sum_next, {(2*FRAC_BITS){1'b0}}};
            rem   <= '0;
            step  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring divide, one quotient bit a cycle, quotient fills num
          rem  <= unit_res.ge ? unit_res.diff : unit_a;
          num  <= {num[DIVD_W-2:0], unit_res.ge};
          step <= step + 1'b1;
          if (step == STEP_W'(DIVD_W - 1)) begin
            rem   <= '0;
            root  <= '0;
            step  <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          // bit-pair square root, one root bit a cycle
          rem  <= unit_res.ge ? unit_res.diff : unit_a;
          root <= root_next;
          num  <= {num[DIVD_W-3:0], 2'b00};
          step <= step + 1'b1;
          if (step == STEP_W'(SQRT_STEPS - 1)) begin
            rms_level     <= root_next;
            overlong      <= overflow_seen;
            done          <= 1'b1;
            square_sum    <= '0;
            sample_count  <= '0;
            overflow_seen <= 1'b0;
            state         <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Checks
  `FRM_ASSERT_IMP(a_done_idle, done, state == S_IDLE, "result strobe while not idle")
  `FRM_ASSERT(a_count_bound, sample_count <= MAX_CNT, "sample count past frame limit")
  `FRM_ASSERT_NXT(a_accept_acc, accept, state == S_ACC, "taken item not accumulated")
  `FRM_ASSERT_IMP(a_done_src, done, $past(state) == S_SQRT || $past(state) == S_ACC, "stray result")
  `FRM_ASSERT_IMP(a_clear_done, done, sample_count == '0 && !overflow_seen, "frame state not cleared")

endmodule
